[src/cvsp_pkg.sv]
`default_nettype none
package cvsp_pkg;

    localparam int CW    = 32;          // coordinate width
    localparam int CFGW  = 31;          // configuration register width
    localparam int VW    = 40;          // internal signed difference width
    localparam int MAGW  = 31;          // magnitude width after norm prescale
    localparam int SW    = 4;           // norm prescale shift width
    localparam int RTW   = 32;          // square root result width
    localparam int SQW   = 2 * RTW;     // sum of squares width
    localparam int NW    = 41;          // norm width after shift back
    localparam int AW    = 32;          // scale factor width
    localparam int PW    = AW + VW;     // product / dividend width
    localparam int QW    = 64;          // scaled result width
    localparam int CAP_SH = 62;         // scale magnitude cap exponent
    localparam int LN    = 3 + RTW;     // norm unit latency
    localparam int LS    = PW + 3;      // scale unit latency

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [VW-1:0] t_val;
    typedef logic        [NW-1:0] t_norm;
    typedef logic signed [QW-1:0] t_wide;

    typedef enum logic [1:0] {
        K_FLAT,
        K_SPH,
        K_CYL,
        K_TOR
    } t_kind;

    localparam logic [1:0] PART_CAP = 2'd0;
    localparam logic [1:0] PART_CYL = 2'd1;
    localparam logic [1:0] PART_TOR = 2'd2;

    localparam logic [2:0] REG_FLAT   = 3'd0;
    localparam logic [2:0] REG_VILLUS = 3'd5;

    localparam logic [2:0] CFG_CRAD  = 3'd0;
    localparam logic [2:0] CFG_CLEN  = 3'd1;
    localparam logic [2:0] CFG_VRAD  = 3'd2;
    localparam logic [2:0] CFG_VLEN  = 3'd3;
    localparam logic [2:0] CFG_WIDTH = 3'd4;

    localparam logic [CFGW-1:0] RST_CRAD  = 31'd65536;
    localparam logic [CFGW-1:0] RST_CLEN  = 31'd262144;
    localparam logic [CFGW-1:0] RST_VRAD  = 31'd65536;
    localparam logic [CFGW-1:0] RST_VLEN  = 31'd262144;
    localparam logic [CFGW-1:0] RST_WIDTH = 31'd1048576;

    typedef struct packed {
        t_coord          px;
        t_coord          py;
        t_coord          pz;
        logic [2:0]      region;
        logic [1:0]      part;
        t_kind           kind;
        logic [CFGW-1:0] rad;
        t_val            bx;
        t_val            by;
        t_val            zc;
        t_val            hx;
        t_val            hy;
        t_val            flat;
        t_norm           nh;
        t_wide           sx;
        t_wide           sy;
        t_val            cx;
        t_val            cy;
        t_val            cz;
        t_val            dx;
        t_val            dy;
        t_val            dz;
        t_norm           ns;
        logic            dg;
    } t_ctx;

    function automatic t_coord sat_coord(input t_wide v);
        t_wide hi;
        t_wide lo;
        hi = (t_wide'(1) <<< (CW - 1)) - t_wide'(1);
        lo = -hi - t_wide'(1);
        if (v > hi) begin
            return CW'(hi);
        end
        if (v < lo) begin
            return CW'(lo);
        end
        return CW'(v);
    endfunction

endpackage
`default_nettype wire

[src/cvsp_norm.sv]
`default_nettype none
module cvsp_norm (
    input  logic           i_clk,
    input  logic           i_en,
    input  cvsp_pkg::t_val i_a,
    input  cvsp_pkg::t_val i_b,
    input  cvsp_pkg::t_val i_c,
    output cvsp_pkg::t_norm o_n
);
    localparam int VW  = cvsp_pkg::VW;
    localparam int MB  = cvsp_pkg::MAGW;
    localparam int SB  = cvsp_pkg::SW;
    localparam int RTW = cvsp_pkg::RTW;
    localparam int SQW = cvsp_pkg::SQW;

    logic [VW-1:0]   n_m [3];
    logic [VW-1:0]   n_mx;
    logic [SB-1:0]   n_s;
    logic [MB-1:0]   r1_m [3];
    logic [SB-1:0]   r1_s;
    logic [2*MB-1:0] r2_sq [3];
    logic [SB-1:0]   r2_s;
    logic [SQW-1:0]  r3_sum;
    logic [SB-1:0]   r3_s;

    logic [SQW-1:0]  n_pn [RTW];
    logic [SQW-1:0]  n_pr [RTW];
    logic [SQW-1:0]  n_t [RTW];
    logic [SQW-1:0]  n_num [RTW];
    logic [SQW-1:0]  n_res [RTW];
    logic [SQW-1:0]  r_num [RTW];
    logic [SQW-1:0]  r_res [RTW];
    logic [SB-1:0]   r_rs [RTW];

    // magnitudes and prescale so each fits MB bits
    always_comb begin
        n_m[0] = i_a[VW-1] ? VW'(-i_a) : VW'(i_a);
        n_m[1] = i_b[VW-1] ? VW'(-i_b) : VW'(i_b);
        n_m[2] = i_c[VW-1] ? VW'(-i_c) : VW'(i_c);
        n_mx = n_m[0];
        if (n_m[1] > n_mx) begin
            n_mx = n_m[1];
        end
        if (n_m[2] > n_mx) begin
            n_mx = n_m[2];
        end
        n_s = '0;
        for (int i = MB; i < VW; i++) begin
            if (n_mx[i]) begin
                n_s = SB'(i - MB + 1);
            end
        end
    end

    // one restoring square root step per stage
    always_comb begin
        n_pn[0] = r3_sum;
        n_pr[0] = '0;
        for (int k = 1; k < RTW; k++) begin
            n_pn[k] = r_num[k-1];
            n_pr[k] = r_res[k-1];
        end
        for (int k = 0; k < RTW; k++) begin
            n_t[k] = n_pr[k] + (SQW'(1) << (SQW - 2 - 2 * k));
            if (n_pn[k] >= n_t[k]) begin
                n_num[k] = n_pn[k] - n_t[k];
                n_res[k] = (n_pr[k] >> 1) + (SQW'(1) << (SQW - 2 - 2 * k));
            end else begin
                n_num[k] = n_pn[k];
                n_res[k] = n_pr[k] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_m[i]  <= MB'(n_m[i] >> n_s);
                r2_sq[i] <= r1_m[i] * r1_m[i];
            end
            r1_s   <= n_s;
            r2_s   <= r1_s;
            r3_sum <= SQW'(r2_sq[0]) + SQW'(r2_sq[1]) + SQW'(r2_sq[2]);
            r3_s   <= r2_s;
            r_rs[0] <= r3_s;
            for (int k = 1; k < RTW; k++) begin
                r_rs[k] <= r_rs[k-1];
            end
            for (int k = 0; k < RTW; k++) begin
                r_num[k] <= n_num[k];
                r_res[k] <= n_res[k];
            end
        end
    end

    assign o_n = cvsp_pkg::NW'(r_res[RTW-1] << r_rs[RTW-1]);

endmodule
`default_nettype wire

[src/cvsp_scale.sv]
`default_nettype none
module cvsp_scale (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [cvsp_pkg::AW-1:0]   i_a,
    input  cvsp_pkg::t_val            i_d,
    input  cvsp_pkg::t_norm           i_n,
    output cvsp_pkg::t_wide           o_q
);
    localparam int VW = cvsp_pkg::VW;
    localparam int AW = cvsp_pkg::AW;
    localparam int NW = cvsp_pkg::NW;
    localparam int PW = cvsp_pkg::PW;
    localparam int QW = cvsp_pkg::QW;
    localparam int HW = VW / 2;
    localparam logic [PW-1:0] CAP = PW'(1) << cvsp_pkg::CAP_SH;

    logic [VW-1:0]      n_md;
    logic [AW+HW-1:0]   r1_pl;
    logic [AW+HW-1:0]   r1_ph;
    logic               r1_sg;
    logic [NW-1:0]      r1_n;
    logic [PW-1:0]      r2_p;
    logic               r2_sg;
    logic [NW-1:0]      r2_n;

    logic [PW-1:0]      n_pd [PW];
    logic [NW-1:0]      n_pr [PW];
    logic [PW-1:0]      n_pq [PW];
    logic [NW-1:0]      n_dd [PW];
    logic [NW:0]        n_t [PW];
    logic [PW-1:0]      n_dv [PW];
    logic [NW-1:0]      n_rm [PW];
    logic [PW-1:0]      n_q [PW];
    logic [PW-1:0]      r_dv [PW];
    logic [NW-1:0]      r_rm [PW];
    logic [PW-1:0]      r_q [PW];
    logic [NW-1:0]      r_dn [PW];
    logic               r_sg [PW];
    logic [PW-1:0]      n_cap;
    cvsp_pkg::t_wide    r_o;

    assign n_md = i_d[VW-1] ? VW'(-i_d) : VW'(i_d);

    // one quotient bit per stage
    always_comb begin
        n_pd[0] = r2_p;
        n_pr[0] = '0;
        n_pq[0] = '0;
        n_dd[0] = r2_n;
        for (int j = 1; j < PW; j++) begin
            n_pd[j] = r_dv[j-1];
            n_pr[j] = r_rm[j-1];
            n_pq[j] = r_q[j-1];
            n_dd[j] = r_dn[j-1];
        end
        for (int j = 0; j < PW; j++) begin
            n_t[j]  = {n_pr[j], n_pd[j][PW-1]};
            n_dv[j] = n_pd[j] << 1;
            if (n_t[j] >= {1'b0, n_dd[j]}) begin
                n_rm[j] = NW'(n_t[j] - {1'b0, n_dd[j]});
                n_q[j]  = {n_pq[j][PW-2:0], 1'b1};
            end else begin
                n_rm[j] = NW'(n_t[j]);
                n_q[j]  = {n_pq[j][PW-2:0], 1'b0};
            end
        end
        n_cap = (r_q[PW-1] > CAP) ? CAP : r_q[PW-1];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pl <= i_a * n_md[HW-1:0];
            r1_ph <= i_a * n_md[VW-1:HW];
            r1_sg <= i_d[VW-1];
            r1_n  <= i_n;
            r2_p  <= PW'(r1_pl) + (PW'(r1_ph) << HW);
            r2_sg <= r1_sg;
            r2_n  <= r1_n;
            r_dn[0] <= r2_n;
            r_sg[0] <= r2_sg;
            for (int j = 1; j < PW; j++) begin
                r_dn[j] <= r_dn[j-1];
                r_sg[j] <= r_sg[j-1];
            end
            for (int j = 0; j < PW; j++) begin
                r_dv[j] <= n_dv[j];
                r_rm[j] <= n_rm[j];
                r_q[j]  <= n_q[j];
            end
            r_o <= r_sg[PW-1] ? -QW'(n_cap) : QW'(n_cap);
        end
    end

    assign o_q = r_o;

endmodule
`default_nettype wire

[src/crypt_villus_surface_projection_top.sv]
`default_nettype none
// Channel   Direction  Signals
// in        sink       i_in_valid / o_in_ready, i_in_x, i_in_y, i_in_z
// out       source     o_out_valid / i_out_ready, o_out_x/y/z, o_region, o_part,
//                      o_degenerate
// cfg       sink       i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data
//
// One point per cycle while the output is not stalled; each result passes in turn
// through a square root pipeline, a divider pipeline, a second square root pipeline
// (one stage per root bit) and a second divider pipeline (one stage per quotient bit).
// Reset is synchronous, active low; it clears valid bits and loads the
// register defaults, and both sink channels hold ready low while it is active.
// A stall at the output freezes the whole pipeline.
module crypt_villus_surface_projection_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [31:0]          i_in_x,
    input  logic signed [31:0]          i_in_y,
    input  logic signed [31:0]          i_in_z,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [31:0]          o_out_x,
    output logic signed [31:0]          o_out_y,
    output logic signed [31:0]          o_out_z,
    output logic [2:0]                  o_region,
    output logic [1:0]                  o_part,
    output logic                        o_degenerate,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [2:0]                  i_cfg_index,
    input  logic [30:0]                 i_cfg_data
);
    localparam int VW = cvsp_pkg::VW;
    localparam int NW = cvsp_pkg::NW;
    localparam int AW = cvsp_pkg::AW;
    localparam int QW = cvsp_pkg::QW;
    localparam int LN = cvsp_pkg::LN;
    localparam int LS = cvsp_pkg::LS;
    localparam int CFGW = cvsp_pkg::CFGW;

    logic [CFGW-1:0] r_crad, r_clen, r_vrad, r_vlen, r_wid;
    logic            en;

    cvsp_pkg::t_val  half, wv, clow, chigh, flatv, vlow, vhigh;
    cvsp_pkg::t_val  cxc [4];
    cvsp_pkg::t_val  cyc [4];

    logic            r_a_v;
    cvsp_pkg::t_ctx  n_a;
    cvsp_pkg::t_ctx  r_a;
    logic [LN-1:0]   r_da_v;
    cvsp_pkg::t_ctx  r_da [LN];
    logic            r_b_v;
    cvsp_pkg::t_ctx  r_b;
    logic [LS-1:0]   r_db_v;
    cvsp_pkg::t_ctx  r_db [LS];
    logic            r_d_v;
    cvsp_pkg::t_ctx  r_d;
    logic [LN-1:0]   r_dd_v;
    cvsp_pkg::t_ctx  r_dd [LN];
    logic            r_e_v;
    cvsp_pkg::t_ctx  r_e;
    logic [LS-1:0]   r_de_v;
    cvsp_pkg::t_ctx  r_de [LS];

    logic                r_o_v;
    cvsp_pkg::t_coord    r_ox, r_oy, r_oz;
    logic [2:0]          r_oreg;
    logic [1:0]          r_opart;
    logic                r_odg;

    cvsp_pkg::t_val  hxa [4];
    cvsp_pkg::t_val  hya [4];
    cvsp_pkg::t_norm nk [4];
    cvsp_pkg::t_norm nv;
    cvsp_pkg::t_val  vhx, vhy;
    cvsp_pkg::t_wide q0, q1, qs0, qs1, qs2;
    cvsp_pkg::t_norm nsph;

    cvsp_pkg::t_ctx  n_b, n_d, n_e, ta, tb, td, te;
    logic            cf, vil;
    logic [1:0]      ck;
    cvsp_pkg::t_val  pzv;
    cvsp_pkg::t_wide n_ox, n_oy, n_oz, pxw, pyw, w64;
    logic [AW-1:0]   b_a;

    assign en          = !r_o_v || i_out_ready;
    assign o_in_ready  = en && i_rst_n;
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crad <= cvsp_pkg::RST_CRAD;
            r_clen <= cvsp_pkg::RST_CLEN;
            r_vrad <= cvsp_pkg::RST_VRAD;
            r_vlen <= cvsp_pkg::RST_VLEN;
            r_wid  <= cvsp_pkg::RST_WIDTH;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                cvsp_pkg::CFG_CRAD:  r_crad <= i_cfg_data;
                cvsp_pkg::CFG_CLEN:  r_clen <= i_cfg_data;
                cvsp_pkg::CFG_VRAD:  r_vrad <= i_cfg_data;
                cvsp_pkg::CFG_VLEN:  r_vlen <= i_cfg_data;
                cvsp_pkg::CFG_WIDTH: r_wid  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // geometry from the registers
    assign half  = VW'(r_wid >> 1);
    assign wv    = VW'(r_wid);
    assign clow  = VW'(r_crad);
    assign chigh = clow + VW'(r_clen);
    assign flatv = VW'({r_crad, 1'b0}) + VW'(r_clen);
    assign vlow  = flatv + VW'(r_vrad);
    assign vhigh = vlow + VW'(r_vlen);
    assign cxc[0] = half;
    assign cyc[0] = '0;
    assign cxc[1] = '0;
    assign cyc[1] = half;
    assign cxc[2] = half;
    assign cyc[2] = wv;
    assign cxc[3] = wv;
    assign cyc[3] = half;

    // horizontal norms to every center
    for (genvar k = 0; k < 4; k++) begin : g_hn
        assign hxa[k] = VW'(r_a.px) - cxc[k];
        assign hya[k] = VW'(r_a.py) - cyc[k];
        cvsp_norm u_norm (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (hxa[k]),
            .i_b   (hya[k]),
            .i_c   ('0),
            .o_n   (nk[k])
        );
    end
    assign vhx = VW'(r_a.px) - half;
    assign vhy = VW'(r_a.py) - half;
    cvsp_norm u_norm_v (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (vhx),
        .i_b   (vhy),
        .i_c   ('0),
        .o_n   (nv)
    );

    // region and part selection
    always_comb begin
        ta  = r_da[LN-1];
        pzv = VW'(ta.pz);
        cf  = 1'b0;
        ck  = '0;
        for (int k = 3; k >= 0; k--) begin
            if (nk[k] < NW'({r_crad, 1'b0})) begin
                cf = 1'b1;
                ck = 2'(k);
            end
        end
        vil = !cf && (nv < NW'({r_vrad, 1'b0}));
        n_b = ta;
        n_b.flat = flatv;
        n_b.zc   = '0;
        if (cf) begin
            n_b.region = 3'(ck) + 3'd1;
            n_b.bx  = cxc[ck];
            n_b.by  = cyc[ck];
            n_b.rad = r_crad;
            n_b.nh  = nk[ck];
            if (pzv <= clow) begin
                n_b.kind = cvsp_pkg::K_SPH;
                n_b.part = cvsp_pkg::PART_CAP;
                n_b.zc   = clow;
            end else if (pzv < chigh) begin
                n_b.kind = cvsp_pkg::K_CYL;
                n_b.part = cvsp_pkg::PART_CYL;
            end else begin
                n_b.kind = cvsp_pkg::K_TOR;
                n_b.part = cvsp_pkg::PART_TOR;
                n_b.zc   = chigh;
            end
        end else begin
            n_b.bx  = half;
            n_b.by  = half;
            n_b.rad = r_vrad;
            n_b.nh  = nv;
            if (!vil) begin
                n_b.region = cvsp_pkg::REG_FLAT;
                n_b.kind   = cvsp_pkg::K_FLAT;
                n_b.part   = cvsp_pkg::PART_CAP;
            end else begin
                n_b.region = cvsp_pkg::REG_VILLUS;
                if (pzv <= vlow) begin
                    n_b.kind = cvsp_pkg::K_TOR;
                    n_b.part = cvsp_pkg::PART_TOR;
                    n_b.zc   = vlow;
                end else if (pzv < vhigh) begin
                    n_b.kind = cvsp_pkg::K_CYL;
                    n_b.part = cvsp_pkg::PART_CYL;
                end else begin
                    n_b.kind = cvsp_pkg::K_SPH;
                    n_b.part = cvsp_pkg::PART_CAP;
                    n_b.zc   = vhigh;
                end
            end
        end
        n_b.hx = VW'(ta.px) - n_b.bx;
        n_b.hy = VW'(ta.py) - n_b.by;
        n_b.dg = (n_b.kind == cvsp_pkg::K_CYL || n_b.kind == cvsp_pkg::K_TOR)
                 && (n_b.nh == '0);
    end

    // cylinder point or ring center
    assign b_a = (r_b.kind == cvsp_pkg::K_TOR) ? {r_b.rad, 1'b0} : AW'(r_b.rad);

    cvsp_scale u_scale_hx (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (b_a),
        .i_d   (r_b.hx),
        .i_n   ((r_b.nh == '0) ? NW'(1) : r_b.nh),
        .o_q   (q0)
    );
    cvsp_scale u_scale_hy (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (b_a),
        .i_d   (r_b.hy),
        .i_n   ((r_b.nh == '0) ? NW'(1) : r_b.nh),
        .o_q   (q1)
    );

    always_comb begin
        tb   = r_db[LS-1];
        n_d  = tb;
        n_d.sx = QW'(tb.bx) + q0;
        n_d.sy = QW'(tb.by) + q1;
        if (tb.kind == cvsp_pkg::K_TOR) begin
            n_d.cx = VW'(n_d.sx);
            n_d.cy = VW'(n_d.sy);
        end else begin
            n_d.cx = tb.bx;
            n_d.cy = tb.by;
        end
        n_d.cz = tb.zc;
        n_d.dx = VW'(tb.px) - n_d.cx;
        n_d.dy = VW'(tb.py) - n_d.cy;
        n_d.dz = VW'(tb.pz) - n_d.cz;
    end

    cvsp_norm u_norm_s (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_d.dx),
        .i_b   (r_d.dy),
        .i_c   (r_d.dz),
        .o_n   (nsph)
    );

    always_comb begin
        td   = r_dd[LN-1];
        n_e  = td;
        n_e.ns = nsph;
        n_e.dg = td.dg || ((td.kind == cvsp_pkg::K_SPH || td.kind == cvsp_pkg::K_TOR)
                 && (nsph == '0));
    end

    cvsp_scale u_scale_sx (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (AW'(r_e.rad)),
        .i_d   (r_e.dx),
        .i_n   ((r_e.ns == '0) ? NW'(1) : r_e.ns),
        .o_q   (qs0)
    );
    cvsp_scale u_scale_sy (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (AW'(r_e.rad)),
        .i_d   (r_e.dy),
        .i_n   ((r_e.ns == '0) ? NW'(1) : r_e.ns),
        .o_q   (qs1)
    );
    cvsp_scale u_scale_sz (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (AW'(r_e.rad)),
        .i_d   (r_e.dz),
        .i_n   ((r_e.ns == '0) ? NW'(1) : r_e.ns),
        .o_q   (qs2)
    );

    // final point, edge reflection, saturation
    always_comb begin
        te  = r_de[LS-1];
        pxw = QW'(te.px);
        pyw = QW'(te.py);
        w64 = QW'(wv);
        case (te.kind)
            cvsp_pkg::K_SPH, cvsp_pkg::K_TOR: begin
                n_ox = QW'(te.cx) + qs0;
                n_oy = QW'(te.cy) + qs1;
                n_oz = QW'(te.cz) + qs2;
            end
            cvsp_pkg::K_CYL: begin
                n_ox = te.sx;
                n_oy = te.sy;
                n_oz = QW'(te.pz);
            end
            default: begin
                n_ox = pxw;
                n_oy = pyw;
                n_oz = QW'(te.flat);
            end
        endcase
        if (te.dg) begin
            n_ox = pxw;
            n_oy = pyw;
            n_oz = QW'(te.pz);
        end else begin
            if (pxw < 0) begin
                n_ox = -pxw;
            end
            if (pxw > w64) begin
                n_ox = (w64 <<< 1) - pxw;
            end
            if (pyw < 0) begin
                n_oy = -pyw;
            end
            if (pyw > w64) begin
                n_oy = (w64 <<< 1) - pyw;
            end
        end
    end

    always_comb begin
        n_a    = '0;
        n_a.px = i_in_x;
        n_a.py = i_in_y;
        n_a.pz = i_in_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v  <= 1'b0;
            r_da_v <= '0;
            r_b_v  <= 1'b0;
            r_db_v <= '0;
            r_d_v  <= 1'b0;
            r_dd_v <= '0;
            r_e_v  <= 1'b0;
            r_de_v <= '0;
            r_o_v  <= 1'b0;
        end else if (en) begin
            r_a_v  <= i_in_valid;
            r_da_v <= {r_da_v[LN-2:0], r_a_v};
            r_b_v  <= r_da_v[LN-1];
            r_db_v <= {r_db_v[LS-2:0], r_b_v};
            r_d_v  <= r_db_v[LS-1];
            r_dd_v <= {r_dd_v[LN-2:0], r_d_v};
            r_e_v  <= r_dd_v[LN-1];
            r_de_v <= {r_de_v[LS-2:0], r_e_v};
            r_o_v  <= r_de_v[LS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a <= n_a;
            r_da[0] <= r_a;
            for (int i = 1; i < LN; i++) begin
                r_da[i] <= r_da[i-1];
                r_dd[i] <= r_dd[i-1];
            end
            r_b <= n_b;
            r_db[0] <= r_b;
            for (int i = 1; i < LS; i++) begin
                r_db[i] <= r_db[i-1];
                r_de[i] <= r_de[i-1];
            end
            r_d <= n_d;
            r_dd[0] <= r_d;
            r_e <= n_e;
            r_de[0] <= r_e;
            r_ox    <= cvsp_pkg::sat_coord(n_ox);
            r_oy    <= cvsp_pkg::sat_coord(n_oy);
            r_oz    <= cvsp_pkg::sat_coord(n_oz);
            r_oreg  <= te.region;
            r_opart <= te.part;
            r_odg   <= te.dg;
        end
    end

    assign o_out_valid  = r_o_v;
    assign o_out_x      = r_ox;
    assign o_out_y      = r_oy;
    assign o_out_z      = r_oz;
    assign o_region     = r_oreg;
    assign o_part       = r_opart;
    assign o_degenerate = r_odg;

    // flat floor never divides, so it is never degenerate
    a_flat_not_dg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_region == cvsp_pkg::REG_FLAT) |-> !o_degenerate)
        else $error("flat region flagged degenerate");

    a_flat_part: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_region == cvsp_pkg::REG_FLAT) |-> (o_part == cvsp_pkg::PART_CAP))
        else $error("flat region with nonzero part");

    a_cyl_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_part == cvsp_pkg::PART_CYL) |->
        (o_region != cvsp_pkg::REG_FLAT) && (o_region <= cvsp_pkg::REG_VILLUS))
        else $error("cylinder part outside crypt or villus");

endmodule
`default_nettype wire
